// ----- rtl/thermal_speed_derating_macros.svh -----
// Assertion macros used by the thermal speed derating checker
`ifndef THERMAL_SPEED_DERATING_MACROS_SVH
`define THERMAL_SPEED_DERATING_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define TSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tsd_pkg.sv -----
// Package: constants, types and register codes of the thermal speed derating block
package tsd_pkg;

    localparam int LEVEL_WORDS       = 3;
    localparam int NUM_LEVELS_DEF    = 3;
    localparam int ENTRY_SAMPLES_DEF = 100;
    localparam int EXIT_SAMPLES_DEF  = 200;

    localparam int WORD_W = 48;
    localparam int CFG_W  = 3;
    localparam int Q_W    = 15;

    localparam logic [WORD_W-1:0] LEVEL0_RST = 48'd9448990311400;
    localparam logic [WORD_W-1:0] LEVEL1_RST = 48'd8590003405900;
    localparam logic [WORD_W-1:0] LEVEL2_RST = 48'd6442526311600;
    localparam logic [1:0]        LEVELS_RST = 2'd3;
    localparam logic [15:0]       DEF_CAP_RST = 16'd3000;
    localparam logic [15:0]       MAX_RPM_RST = 16'd3000;

    localparam logic signed [15:0] Q15_MAX = 16'sd32767;

    typedef enum logic [CFG_W-1:0] {
        CFG_LEVEL0   = 3'd0,
        CFG_LEVEL1   = 3'd1,
        CFG_LEVEL2   = 3'd2,
        CFG_LEVELS   = 3'd3,
        CFG_DEF_CAP  = 3'd4,
        CFG_MAX_RPM  = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXIT,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       scan;
        logic       exit_step;
        logic       first;
        logic [1:0] idx;
    } t_lvl_ctrl;

endpackage

// ----- rtl/tsd_ifs.sv -----
// Channel interfaces: input items, result items and configuration writes
interface tsd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] speed_request;
    logic signed [15:0] temperature;

    modport source (output valid, speed_request, temperature, input ready);
    modport sink (input valid, speed_request, temperature, output ready);
endinterface

interface tsd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] limited_speed;
    logic        [15:0] allowed_rpm;
    logic        [1:0]  active_level;

    modport source (output valid, limited_speed, allowed_rpm, active_level, input ready);
    modport sink (input valid, limited_speed, allowed_rpm, active_level, output ready);
endinterface

interface tsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/tsd_levels.sv -----
// Level tracker: entry/exit counters and active level, one level per step
module tsd_levels #(
    parameter int NUM_LEVELS    = tsd_pkg::NUM_LEVELS_DEF,
    parameter int ENTRY_SAMPLES = tsd_pkg::ENTRY_SAMPLES_DEF,
    parameter int EXIT_SAMPLES  = tsd_pkg::EXIT_SAMPLES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tsd_pkg::t_lvl_ctrl      i_ctrl,
    input  logic signed [15:0]      i_temperature,
    input  logic [tsd_pkg::WORD_W-1:0] i_level_word [tsd_pkg::LEVEL_WORDS],
    output logic [1:0]              o_cur_level
);
    import tsd_pkg::*;

    localparam int NL = (NUM_LEVELS < LEVEL_WORDS) ? NUM_LEVELS : LEVEL_WORDS;
    localparam int EW = $clog2(ENTRY_SAMPLES + 1);
    localparam int XW = $clog2(EXIT_SAMPLES + 1);

    logic [EW-1:0]     r_entry [NL];
    logic [XW-1:0]     r_exit  [NL];
    logic [1:0]        r_cand;
    logic [1:0]        r_cur;

    logic [1:0]        sel;
    logic [WORD_W-1:0] word;
    logic              ge_act;
    logic              lt_deact;
    logic [EW-1:0]     entry_sel;
    logic [XW-1:0]     exit_sel;
    logic [EW-1:0]     entry_nxt;
    logic [XW-1:0]     exit_nxt;
    logic              entry_full;
    logic              exit_full;

    assign sel = i_ctrl.exit_step ? (r_cur - 2'd1) : i_ctrl.idx;

    always_comb begin
        case (sel)
            2'd0:    word = i_level_word[0];
            2'd1:    word = i_level_word[1];
            2'd2:    word = i_level_word[2];
            default: word = '0;
        endcase
    end

    // shared threshold compare
    assign ge_act   = i_temperature >= $signed(word[15:0]);
    assign lt_deact = i_temperature <  $signed(word[31:16]);

    always_comb begin
        entry_sel = '0;
        exit_sel  = '0;
        for (int g = 0; g < NL; g++) begin
            if (sel == 2'(g)) begin
                entry_sel = r_entry[g];
                exit_sel  = r_exit[g];
            end
        end
    end

    always_comb begin
        if (!ge_act) begin
            entry_nxt = '0;
        end else if (entry_sel < EW'(ENTRY_SAMPLES)) begin
            entry_nxt = entry_sel + EW'(1);
        end else begin
            entry_nxt = entry_sel;
        end
        if (exit_sel < XW'(EXIT_SAMPLES)) begin
            exit_nxt = exit_sel + XW'(1);
        end else begin
            exit_nxt = exit_sel;
        end
    end

    assign entry_full = ge_act && (entry_nxt == EW'(ENTRY_SAMPLES));
    assign exit_full  = exit_nxt == XW'(EXIT_SAMPLES);

    for (genvar g = 0; g < NL; g++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_entry[g] <= '0;
                r_exit[g]  <= '0;
            end else if (i_ctrl.scan && (i_ctrl.idx == 2'(g))) begin
                r_entry[g] <= entry_nxt;
                if (!lt_deact) begin
                    r_exit[g] <= '0;
                end
            end else if (i_ctrl.exit_step && (r_cur != 2'd0) && (sel == 2'(g))) begin
                r_exit[g] <= lt_deact ? exit_nxt : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
            r_cur  <= '0;
        end else begin
            if (i_ctrl.scan) begin
                if (entry_full) begin
                    r_cand <= i_ctrl.idx + 2'd1;
                end else if (i_ctrl.first) begin
                    r_cand <= '0;
                end
            end
            if (i_ctrl.exit_step) begin
                if (r_cur == 2'd0) begin
                    if (r_cand != 2'd0) begin
                        r_cur <= r_cand;
                    end
                end else if (lt_deact) begin
                    if (exit_full) begin
                        r_cur <= r_cand;
                    end
                end else if (r_cand > r_cur) begin
                    r_cur <= r_cand;
                end
            end
        end
    end

    assign o_cur_level = r_cur;

endmodule

// ----- rtl/tsd_div.sv -----
// Restoring divider: rpm * 32767 / motor_max, one quotient bit per cycle
module tsd_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [15:0]             i_rpm,
    input  logic [15:0]             i_max,
    output logic                    o_done,
    output logic [tsd_pkg::Q_W-1:0] o_quot
);
    import tsd_pkg::*;

    localparam int CW = $clog2(Q_W);

    logic [30:0]    num;
    logic [15:0]    r_rem;
    logic [Q_W-1:0] r_low;
    logic [Q_W-1:0] r_quot;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [16:0]    trial;
    logic [16:0]    diff;

    // rpm * (2^15 - 1)
    assign num   = {i_rpm, 15'd0} - {15'd0, i_rpm};
    assign trial = {r_rem, r_low[Q_W-1]};
    assign diff  = trial - {1'b0, i_max};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= num[30:15];
            r_low  <= num[Q_W-1:0];
            r_quot <= '0;
        end else if (r_busy) begin
            r_low <= {r_low[Q_W-2:0], 1'b0};
            if (!diff[16]) begin
                r_rem  <= diff[15:0];
                r_quot <= {r_quot[Q_W-2:0], 1'b1};
            end else begin
                r_rem  <= trial[15:0];
                r_quot <= {r_quot[Q_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/thermal_speed_derating.sv -----
// Top level: thermal speed derating with hysteresis, sequencer and registers
// One item is taken at a time. After acceptance the sequencer steps through the
// min(levels_in_use, NUM_LEVELS, 3) enabled levels one per cycle, steps the active
// level's exit counter, then loads the rpm cap and runs the 15-step restoring
// divider that turns the cap into Q15. With derating disabled the level scan and
// exit steps are skipped. Before it takes the next item the sequencer waits until
// a full output register has room for the result. The result sits in an output
// register, and a new item is taken while it waits. Configuration writes are
// always ready and must only arrive while no item is in flight.
module thermal_speed_derating #(
    parameter int NUM_LEVELS    = tsd_pkg::NUM_LEVELS_DEF,
    parameter int ENTRY_SAMPLES = tsd_pkg::ENTRY_SAMPLES_DEF,
    parameter int EXIT_SAMPLES  = tsd_pkg::EXIT_SAMPLES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tsd_in_if.sink   i_in,
    tsd_out_if.source o_out,
    tsd_cfg_if.sink  i_cfg
);
    import tsd_pkg::*;

    localparam int         NL  = (NUM_LEVELS < LEVEL_WORDS) ? NUM_LEVELS : LEVEL_WORDS;
    localparam logic [1:0] NL2 = 2'(NL);

    t_state             r_state;
    t_state             n_state;

    logic [WORD_W-1:0]  r_level_word [LEVEL_WORDS];
    logic [1:0]         r_levels;
    logic [15:0]        r_def_cap;
    logic [15:0]        r_max_rpm;

    logic signed [15:0] r_req;
    logic signed [15:0] r_temp;
    logic [1:0]         r_n;
    logic [1:0]         r_idx;
    logic [15:0]        r_allowed;
    logic [1:0]         r_shown;

    logic               r_out_valid;
    logic signed [15:0] r_out_speed;
    logic [15:0]        r_out_rpm;
    logic [1:0]         r_out_level;

    logic               in_beat;
    logic               out_free;
    logic [1:0]         n_clip;
    logic [1:0]         cur_level;
    logic [15:0]        lvl_cap;
    logic [15:0]        allowed_c;
    logic               div_start;
    logic               div_done;
    logic [Q_W-1:0]     quot;
    logic signed [15:0] cap_q15;
    logic               out_load;
    logic               in_ready;
    t_lvl_ctrl          lvl_ctrl;

    assign in_beat  = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign n_clip   = (r_levels > NL2) ? NL2 : r_levels;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_word[0] <= LEVEL0_RST;
            r_level_word[1] <= LEVEL1_RST;
            r_level_word[2] <= LEVEL2_RST;
            r_levels        <= LEVELS_RST;
            r_def_cap       <= DEF_CAP_RST;
            r_max_rpm       <= MAX_RPM_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_LEVEL0:  r_level_word[0] <= i_cfg.data;
                CFG_LEVEL1:  r_level_word[1] <= i_cfg.data;
                CFG_LEVEL2:  r_level_word[2] <= i_cfg.data;
                CFG_LEVELS:  r_levels        <= i_cfg.data[1:0];
                CFG_DEF_CAP: r_def_cap       <= i_cfg.data[15:0];
                CFG_MAX_RPM: r_max_rpm       <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = (n_clip != 2'd0) ? ST_SCAN : ST_PREP;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_n - 2'd1) begin
                    n_state = ST_EXIT;
                end
            end
            ST_EXIT: n_state = ST_PREP;
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready           = 1'b0;
        div_start          = 1'b0;
        out_load           = 1'b0;
        lvl_ctrl.scan      = 1'b0;
        lvl_ctrl.exit_step = 1'b0;
        lvl_ctrl.first     = (r_idx == 2'd0);
        lvl_ctrl.idx       = r_idx;
        case (r_state)
            ST_IDLE: in_ready           = 1'b1;
            ST_SCAN: lvl_ctrl.scan      = 1'b1;
            ST_EXIT: lvl_ctrl.exit_step = 1'b1;
            ST_PREP: div_start          = 1'b1;
            ST_DONE: out_load           = out_free;
            default: ;
        endcase
    end

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (in_beat) begin
            r_idx <= '0;
        end else if (lvl_ctrl.scan) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_req  <= i_in.speed_request;
            r_temp <= i_in.temperature;
            r_n    <= n_clip;
        end
        if (div_start) begin
            r_allowed <= allowed_c;
            r_shown   <= (r_n == 2'd0) ? 2'd0 : cur_level;
        end
    end

    tsd_levels #(
        .NUM_LEVELS    (NUM_LEVELS),
        .ENTRY_SAMPLES (ENTRY_SAMPLES),
        .EXIT_SAMPLES  (EXIT_SAMPLES)
    ) u_levels (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (lvl_ctrl),
        .i_temperature (r_temp),
        .i_level_word  (r_level_word),
        .o_cur_level   (cur_level)
    );

    // rpm cap of the active level
    always_comb begin
        case (cur_level)
            2'd1:    lvl_cap = r_level_word[0][47:32];
            2'd2:    lvl_cap = r_level_word[1][47:32];
            2'd3:    lvl_cap = r_level_word[2][47:32];
            default: lvl_cap = r_def_cap;
        endcase
    end

    assign allowed_c = ((r_n != 2'd0) && (lvl_cap < r_def_cap)) ? lvl_cap : r_def_cap;

    tsd_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_rpm     (allowed_c),
        .i_max     (r_max_rpm),
        .o_done    (div_done),
        .o_quot    (quot)
    );

    always_comb begin
        if (r_max_rpm == 16'd0) begin
            cap_q15 = '0;
        end else if (r_allowed >= r_max_rpm) begin
            cap_q15 = Q15_MAX;
        end else begin
            cap_q15 = $signed({1'b0, quot});
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_speed <= (r_req > cap_q15) ? cap_q15 : r_req;
            r_out_rpm   <= r_allowed;
            r_out_level <= r_shown;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.limited_speed = r_out_speed;
    assign o_out.allowed_rpm   = r_out_rpm;
    assign o_out.active_level  = r_out_level;

endmodule

// ----- rtl/tsd_checker.sv -----
// Port-level checker for the thermal speed derating block, with its bind
`include "thermal_speed_derating_macros.svh"

module tsd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // a result waiting for the sink stays offered
    `TSD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result beat dropped while stalled")

    // an accepted item keeps the block busy and the input not ready after the beat
    `TSD_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready ##1 !i_in_ready, "input taken while an item is in work")

    // a new result only appears at the end of an item's work
    `TSD_ASSERT_NOW(a_out_from_work, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "result beat without an item in work")

endmodule

bind thermal_speed_derating tsd_checker u_tsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

// ----- tb/tb_thermal_speed_derating.sv -----
// Testbench for thermal_speed_derating: directed rows, then random hot/cool episodes
`timescale 1ns / 100ps

module tb_thermal_speed_derating;
    import tsd_pkg::*;

    localparam int ENTRY_N       = ENTRY_SAMPLES_DEF;
    localparam int EXIT_N        = EXIT_SAMPLES_DEF;
    localparam int LVL_N         = NUM_LEVELS_DEF;
    localparam int LAT_CYC       = 30;
    localparam int LONG_HOLD     = 400;
    localparam int WDOG_LIMIT    = 2000;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 180;
    localparam int ERR_PRINT_MAX = 100;

    typedef struct packed {
        logic signed [15:0] speed;
        logic        [15:0] rpm;
        logic        [1:0]  lvl;
    } t_derate;

    typedef struct packed {
        bit                 is_reg;
        t_cfg_idx           idx;
        logic        [47:0] data;
        logic signed [15:0] req;
        logic signed [15:0] temp;
        bit                 typed;
        t_derate            want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    tsd_in_if  in_ch ();
    tsd_out_if out_ch ();
    tsd_cfg_if cfg_ch ();

    thermal_speed_derating DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor copy of registers and hysteresis state
    logic [47:0] lvl_word [3] = '{LEVEL0_RST, LEVEL1_RST, LEVEL2_RST};
    logic [1:0]  lvl_enabled  = LEVELS_RST;
    logic [15:0] def_cap      = DEF_CAP_RST;
    logic [15:0] max_rpm      = MAX_RPM_RST;
    logic [6:0]  above_cnt [3] = '{default: '0};
    logic [7:0]  below_cnt [3] = '{default: '0};
    logic [1:0]  derate_lvl   = 2'd0;

    t_derate pending_limits [$];
    int      err_cnt        = 0;
    int      results_seen   = 0;
    int      burst_left     = 0;
    bit      items_unsettled = 1'b0;
    bit      long_hold_done = 1'b0;

    // directed rows: typed expectations where the answer is obvious, predicted ones elsewhere
    t_dir_row dir_rows [0:30] = '{
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd32767, 16'sd0, 1'b1, '{16'sd32767, 16'd3000, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sh8000, 16'sh8000, 1'b1, '{16'sh8000, 16'd3000, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd0, 16'sd32767, 1'b1, '{16'sd0, 16'd3000, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd1, -16'sd1, 1'b1, '{16'sd1, 16'd3000, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, -16'sd1, 16'sd1000, 1'b1, '{-16'sd1, 16'd3000, 2'd0}},
        '{1'b1, CFG_MAX_RPM, 48'd0, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd32767, 16'sd999, 1'b1, '{16'sd0, 16'd3000, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sh8000, 16'sd1000, 1'b1, '{16'sh8000, 16'd3000, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd0, 16'sd1100, 1'b1, '{16'sd0, 16'd3000, 2'd0}},
        '{1'b1, CFG_MAX_RPM, 48'd65535, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b1, CFG_DEF_CAP, 48'd65535, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd32767, 16'sd1200, 1'b1, '{16'sd32767, 16'd65535, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, -16'sd5, 16'sd1199, 1'b1, '{-16'sd5, 16'd65535, 2'd0}},
        '{1'b1, CFG_DEF_CAP, 48'd0, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd100, 16'sd0, 1'b1, '{16'sd0, 16'd0, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, -16'sd100, 16'sd0, 1'b1, '{-16'sd100, 16'd0, 2'd0}},
        '{1'b1, CFG_LEVELS, 48'd0, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b1, CFG_DEF_CAP, 48'd1500, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b1, CFG_MAX_RPM, 48'd3000, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd32767, 16'sd32767, 1'b1, '{16'sd16383, 16'd1500, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd16384, 16'sh8000, 1'b1, '{16'sd16383, 16'd1500, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd16383, 16'sd0, 1'b1, '{16'sd16383, 16'd1500, 2'd0}},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sh8000, 16'sd5, 1'b1, '{16'sh8000, 16'd1500, 2'd0}},
        '{1'b1, CFG_LEVEL0, 48'hFFFF_7FFF_8000, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b1, CFG_LEVEL1, 48'h0000_8000_7FFF, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b1, CFG_LEVEL2, 48'hFFFF_FFFF_FFFF, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b1, CFG_LEVELS, 48'd3, 16'sd0, 16'sd0, 1'b0, '0},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd12345, 16'sd32767, 1'b0, '0},
        '{1'b0, CFG_LEVEL0, 48'd0, -16'sd12345, 16'sh8000, 1'b0, '0},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd32767, -16'sd1, 1'b0, '0},
        '{1'b0, CFG_LEVEL0, 48'd0, 16'sd0, 16'sd0, 1'b0, '0}
    };

    function automatic int act_thr(int k);
        return int'(signed'(lvl_word[k][15:0]));
    endfunction

    function automatic int deact_thr(int k);
        return int'(signed'(lvl_word[k][31:16]));
    endfunction

    function automatic logic signed [15:0] sat16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // advances hysteresis state by one sample and returns the clamped speed, allowed rpm and level
    function automatic t_derate derate_sample(logic signed [15:0] req, logic signed [15:0] temp);
        int          n;
        int          cand;
        int          c;
        int unsigned allowed;
        int          cap_q;
        t_derate     r;
        n       = (int'(lvl_enabled) > LVL_N) ? LVL_N : int'(lvl_enabled);
        allowed = def_cap;
        r.lvl   = 2'd0;
        if (n > 0) begin
            cand = 0;
            for (int i = 0; i < n; i++) begin
                if (temp < act_thr(i)) above_cnt[i] = '0;
                if (temp >= deact_thr(i)) below_cnt[i] = '0;
            end
            for (int i = 0; i < n; i++) begin
                if (temp >= act_thr(i)) begin
                    if (above_cnt[i] < ENTRY_N) above_cnt[i]++;
                    if (above_cnt[i] >= ENTRY_N) cand = i + 1;
                end
            end
            if (derate_lvl != 2'd0) begin
                c = int'(derate_lvl) - 1;
                if (temp < deact_thr(c)) begin
                    if (below_cnt[c] < EXIT_N) below_cnt[c]++;
                    if (below_cnt[c] >= EXIT_N) derate_lvl = cand[1:0];
                end else begin
                    below_cnt[c] = '0;
                    if (cand > int'(derate_lvl)) derate_lvl = cand[1:0];
                end
            end else if (cand != 0) begin
                derate_lvl = cand[1:0];
            end
            if (derate_lvl != 2'd0 && lvl_word[derate_lvl - 1][47:32] < allowed)
                allowed = lvl_word[derate_lvl - 1][47:32];
            r.lvl = derate_lvl;
        end
        if (max_rpm == 16'd0) cap_q = 0;
        else if (allowed >= max_rpm) cap_q = 32767;
        else cap_q = int'((allowed * 32767) / max_rpm);
        r.speed = (int'(req) > cap_q) ? cap_q[15:0] : req;
        r.rpm   = allowed[15:0];
        return r;
    endfunction

    task automatic send_sample(logic signed [15:0] req, logic signed [15:0] temp, bit typed,
                               t_derate want);
        t_derate r;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        in_ch.valid         <= 1'b1;
        in_ch.speed_request <= req;
        in_ch.temperature   <= temp;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        burst_left--;
        items_unsettled = 1'b1;
        r = derate_sample(req, temp);
        pending_limits.push_back(typed ? want : r);
    endtask

    // register writes only once every sample in flight has come out
    task automatic write_reg(t_cfg_idx idx, logic [47:0] data);
        if (items_unsettled) begin
            in_ch.valid <= 1'b0;
            while (pending_limits.size() != 0) @(posedge i_clk);
            repeat (LAT_CYC) @(posedge i_clk);
            items_unsettled = 1'b0;
            burst_left      = 0;
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_LEVEL0, CFG_LEVEL1, CFG_LEVEL2: lvl_word[int'(idx)] = data;
            CFG_LEVELS:  lvl_enabled = data[1:0];
            CFG_DEF_CAP: def_cap = data[15:0];
            CFG_MAX_RPM: max_rpm = data[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result checker
    initial begin
        t_derate got;
        t_derate want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                results_seen++;
                got = '{out_ch.limited_speed, out_ch.allowed_rpm, out_ch.active_level};
                if (pending_limits.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= ERR_PRINT_MAX)
                        $display("%0t: unexpected beat: speed %0d rpm %0d level %0d",
                                 $time, got.speed, got.rpm, got.lvl);
                end else begin
                    want = pending_limits.pop_front();
                    if (got.speed !== want.speed) begin
                        err_cnt++;
                        if (err_cnt <= ERR_PRINT_MAX)
                            $display("%0t: limited_speed exp %0d got %0d",
                                     $time, want.speed, got.speed);
                    end
                    if (got.rpm !== want.rpm) begin
                        err_cnt++;
                        if (err_cnt <= ERR_PRINT_MAX)
                            $display("%0t: allowed_rpm exp %0d got %0d",
                                     $time, want.rpm, got.rpm);
                    end
                    if (got.lvl !== want.lvl) begin
                        err_cnt++;
                        if (err_cnt <= ERR_PRINT_MAX)
                            $display("%0t: active_level exp %0d got %0d",
                                     $time, want.lvl, got.lvl);
                    end
                end
            end
        end
    end

    // output backpressure: rotating stall patterns plus one long hold
    initial begin
        int rx_cyc;
        rx_cyc = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cyc++;
            if (!long_hold_done && results_seen >= 300) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            case ((rx_cyc / 97) % 4)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                2:       out_ch.ready <= (rx_cyc % 7 == 0);
                default: out_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // watchdog on cycles with no beat on any channel
    initial begin
        int idle_cyc;
        idle_cyc = 0;
        while (idle_cyc < WDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                idle_cyc = 0;
            else
                idle_cyc++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          sent;
        int          kind;
        int          run;
        int          lv;
        int          t;
        int          req;
        int          lo_deact;
        int          base;
        int          step;
        int          act;
        int          deact;
        int          nlev;
        logic [63:0] rnd;
        logic [47:0] word;

        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.speed_request <= '0;
        in_ch.temperature   <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_LEVEL0;
        cfg_ch.data         <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_reg)
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            else
                send_sample(dir_rows[r].req, dir_rows[r].temp, dir_rows[r].typed,
                            dir_rows[r].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int k = 0; k < 3; k++) begin
                rnd = {$urandom, $urandom};
                if (ph == 2) begin
                    word = rnd[47:0];
                end else begin
                    base  = $urandom_range(0, 2000) - 500;
                    step  = $urandom_range(20, 300);
                    act   = base + k * step;
                    deact = act - $urandom_range(0, 100);
                    word  = {rnd[15:0], deact[15:0], act[15:0]};
                end
                write_reg(t_cfg_idx'(k), word);
            end
            case (ph)
                0, 2:    nlev = 3;
                1:       nlev = 1;
                3:       nlev = 0;
                default: nlev = 2;
            endcase
            rnd = {$urandom, $urandom};
            write_reg(CFG_LEVELS, (ph == 2) ? {rnd[47:2], nlev[1:0]} : 48'(nlev[1:0]));
            case (ph)
                1:       write_reg(CFG_DEF_CAP, 48'd65535);
                2:       write_reg(CFG_DEF_CAP, {rnd[47:16], 16'($urandom)});
                default: write_reg(CFG_DEF_CAP, 48'($urandom_range(0, 65535)));
            endcase
            case (ph)
                1:       write_reg(CFG_MAX_RPM, 48'd65535);
                3:       write_reg(CFG_MAX_RPM, 48'd0);
                4:       write_reg(CFG_MAX_RPM, 48'($urandom_range(1, 100)));
                default: write_reg(CFG_MAX_RPM, 48'($urandom_range(1, 65535)));
            endcase

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                kind = $urandom_range(0, 19);
                lv   = $urandom_range(0, 2);
                if (kind < 8) run = $urandom_range(60, 150);
                else if (kind < 14) run = $urandom_range(150, 240);
                else if (kind < 17) run = $urandom_range(5, 40);
                else run = $urandom_range(1, 8);
                if (run > PHASE_ITEMS - sent) run = PHASE_ITEMS - sent;
                lo_deact = deact_thr(0);
                for (int k = 1; k < 3; k++)
                    if (deact_thr(k) < lo_deact) lo_deact = deact_thr(k);
                for (int j = 0; j < run; j++) begin
                    if (kind < 8) begin
                        // hot: at or above the chosen level's activate threshold
                        t = act_thr(lv) +
                            (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300));
                    end else if (kind < 14) begin
                        // cool: below every deactivate threshold
                        t = lo_deact - $urandom_range(1, 400);
                    end else if (kind < 17) begin
                        // hysteresis band of one level
                        if (act_thr(lv) - deact_thr(lv) > 1)
                            t = deact_thr(lv) +
                                $urandom_range(0, act_thr(lv) - deact_thr(lv) - 1);
                        else
                            t = deact_thr(lv);
                    end else begin
                        t = $urandom_range(0, 65535) - 32768;
                    end
                    case ($urandom_range(0, 7))
                        0:       req = 32767;
                        1:       req = -32768;
                        2:       req = 0;
                        default: req = $urandom_range(0, 65535) - 32768;
                    endcase
                    send_sample(sat16(req), sat16(t), 1'b0, '0);
                end
                sent += run;
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_limits.size() != 0) @(posedge i_clk);
        repeat (LAT_CYC * 2) @(posedge i_clk);
        if (err_cnt == 0 && pending_limits.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
